/* sv/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms. Each expects clk and arst_n in scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

`define ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define ASSERT_ALWAYS(label, prop, msg)
`define ASSERT_SAME(label, ante, cons, msg)
`define ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

/* sv/dadd_pkg.sv */
// ----------------------------------------------------------------------------
// dadd_pkg
// Types, constants and month-length lookup for the date adder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dadd_pkg;

	localparam int YEAR_W  = 14;
	localparam int MONTH_W = 4;
	localparam int DAY_W   = 5;
	localparam int COUNT_W = 16;
	// Holds days_to_add + day + a full year of month lengths.
	localparam int REM_W   = 17;
	localparam int QUOT_W  = 10;
	localparam int PROD_W  = 29;
	localparam int M25_W   = 5;

	localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
	localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
	localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

	localparam logic [DAY_W-1:0] FEB_LEAP   = 5'd29;
	localparam logic [DAY_W-1:0] FEB_COMMON = 5'd28;

	// Year / 25 as (year * RECIP_25) >> RECIP_SHIFT, exact for 14-bit years.
	localparam logic [PROD_W-1:0] RECIP_25    = 29'd20972;
	localparam int                RECIP_SHIFT = 19;
	localparam logic [YEAR_W-1:0] DIV_25      = 14'd25;
	localparam logic [M25_W-1:0]  M25_LAST    = 5'd24;
	localparam logic [YEAR_W-1:0] YEAR_MAX    = 14'h3FFF;

	localparam logic [DAY_W-1:0] MONTH_LEN [12] = '{
		5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
		5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
	};

	typedef struct packed {
		logic [YEAR_W-1:0]  start_year;
		logic [MONTH_W-1:0] start_month;
		logic [DAY_W-1:0]   start_day;
		logic [COUNT_W-1:0] days_to_add;
	} dadd_in_t;

	typedef struct packed {
		logic [YEAR_W-1:0]  end_year;
		logic [MONTH_W-1:0] end_month;
		logic [DAY_W-1:0]   end_day;
	} dadd_out_t;

	typedef struct packed {
		logic load;
		logic mod_fix;
		logic sum_step;
		logic walk_init;
		logic walk_step;
		logic out_load;
	} dadd_cmd_t;

	typedef struct packed {
		logic sum_done;
		logic walk_done;
	} dadd_status_t;

	// Months outside 1..12 have no days.
	function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] mon,
		input logic leap);
		logic [DAY_W-1:0] len;
		len = '0;
		if (mon == MONTH_FEB) begin
			len = leap ? FEB_LEAP : FEB_COMMON;
		end else if (mon >= MONTH_JAN && mon <= MONTH_DEC) begin
			len = MONTH_LEN[mon - MONTH_JAN];
		end
		return len;
	endfunction

endpackage

`default_nettype wire

/* sv/dadd_in_if.sv */
// ----------------------------------------------------------------------------
// dadd_in_if
// Valid/ready channel carrying one starting date and day count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface dadd_in_if import dadd_pkg::*; ();
	logic     valid;
	logic     ready;
	dadd_in_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

/* sv/dadd_out_if.sv */
// ----------------------------------------------------------------------------
// dadd_out_if
// Valid/ready channel carrying one resulting date.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface dadd_out_if import dadd_pkg::*; ();
	logic      valid;
	logic      ready;
	dadd_out_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

/* sv/add_days_to_date.sv */
// ----------------------------------------------------------------------------
// add_days_to_date
// Adds a day count to a Gregorian date by walking month by month.
// ----------------------------------------------------------------------------
//  Channel  Dir  Payload                                            Transfer
//  req      in   start_year, start_month, start_day, days_to_add    valid & ready
//  rsp      out  end_year, end_month, end_day                       valid & ready
//
// With S = max(start_month - 1, 0) and W the number of months the walk crosses
// (up to about 2170), the run after a req transfer grows with S + W. rsp is offered
// and req is ready again together, once the date is loaded, so a new req is not
// taken while one is in work. The single month-length adder, one month per cycle,
// sets this pace.
// Reset clears the sequencer and the output valid flag; no clearing pass.
// A stalled rsp holds the finished date; req is taken again once it is stored.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module add_days_to_date import dadd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	dadd_in_if.sink     req,
	dadd_out_if.source  rsp
);

	dadd_cmd_t    cmd;
	dadd_status_t status;

	dadd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.status    (status),
		.cmd       (cmd)
	);

	dadd_datapath u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_data  (req.data),
		.cmd      (cmd),
		.status   (status),
		.out_data (rsp.data)
	);

endmodule

`default_nettype wire

/* sv/dadd_datapath.sv */
// ----------------------------------------------------------------------------
// dadd_datapath
// Year, month and remaining-day registers with the month-length adder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module dadd_datapath import dadd_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  dadd_in_t     in_data,
	input  dadd_cmd_t    cmd,
	output dadd_status_t status,
	output dadd_out_t    out_data
);

	logic [YEAR_W-1:0]  year_q;
	logic [MONTH_W-1:0] smon_q;
	logic [MONTH_W-1:0] mon_q;
	logic [REM_W-1:0]   rem_q;
	logic [QUOT_W-1:0]  quot_q;
	logic [M25_W-1:0]   m25_q;
	dadd_out_t          out_q;

	logic [PROD_W-1:0]  prod;
	logic [YEAR_W-1:0]  quot_x25;
	logic [YEAR_W-1:0]  year_rem;
	logic               leap;
	logic [DAY_W-1:0]   len;
	logic [REM_W-1:0]   len_ext;

	assign prod     = PROD_W'(in_data.start_year) * RECIP_25;
	assign quot_x25 = YEAR_W'(quot_q) * DIV_25;
	assign year_rem = year_q - quot_x25;

	// Divisible by 400 means by 16 and by 25; by 4 and not 100 means by 4 and not 25.
	assign leap = (m25_q == '0) ? (year_q[3:0] == 4'd0) : (year_q[1:0] == 2'd0);

	assign len     = month_days(mon_q, leap);
	assign len_ext = REM_W'(len);

	assign status.sum_done  = (mon_q >= smon_q);
	assign status.walk_done = (rem_q <= len_ext);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			year_q <= in_data.start_year;
			smon_q <= in_data.start_month;
			mon_q  <= MONTH_JAN;
			rem_q  <= REM_W'(in_data.days_to_add) + REM_W'(in_data.start_day);
			quot_q <= prod[RECIP_SHIFT +: QUOT_W];
		end
		if (cmd.mod_fix) begin
			m25_q <= year_rem[M25_W-1:0];
		end
		if (cmd.sum_step) begin
			rem_q <= rem_q + len_ext;
			mon_q <= mon_q + 4'd1;
		end
		if (cmd.walk_init) begin
			mon_q <= MONTH_JAN;
		end
		if (cmd.walk_step) begin
			rem_q <= rem_q - len_ext;
			if (mon_q == MONTH_DEC) begin
				mon_q  <= MONTH_JAN;
				year_q <= year_q + 14'd1;
				// The 14-bit year wraps to zero, which is a multiple of 25.
				if (year_q == YEAR_MAX || m25_q == M25_LAST) begin
					m25_q <= '0;
				end else begin
					m25_q <= m25_q + 5'd1;
				end
			end else begin
				mon_q <= mon_q + 4'd1;
			end
		end
		if (cmd.out_load) begin
			out_q.end_year  <= year_q;
			out_q.end_month <= mon_q;
			out_q.end_day   <= rem_q[DAY_W-1:0];
		end
	end

	assign out_data = out_q;

	`ASSERT_NEXT(a_m25_range, cmd.mod_fix, m25_q < 5'd25, "year remainder mod 25 out of range")
	`ASSERT_SAME(a_walk_month, cmd.walk_step, mon_q >= MONTH_JAN && mon_q <= MONTH_DEC, "walk month out of range")
	`ASSERT_SAME(a_walk_nonzero, cmd.walk_step, rem_q > len_ext, "walk step would underflow")

endmodule

`default_nettype wire

/* sv/dadd_ctrl.sv */
// ----------------------------------------------------------------------------
// dadd_ctrl
// Sequencer: load, year remainder, month sum, month walk, result hand-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module dadd_ctrl import dadd_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	output logic         out_valid,
	input  logic         out_ready,
	input  dadd_status_t status,
	output dadd_cmd_t    cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MOD  = 2'd1;
	localparam logic [1:0] ST_SUM  = 2'd2;
	localparam logic [1:0] ST_WALK = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       out_valid_q;
	logic       out_free;

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_MOD;
				end
			end
			ST_MOD: begin
				cmd.mod_fix = 1'b1;
				state_d     = ST_SUM;
			end
			ST_SUM: begin
				if (status.sum_done) begin
					cmd.walk_init = 1'b1;
					state_d       = ST_WALK;
				end else begin
					cmd.sum_step = 1'b1;
				end
			end
			ST_WALK: begin
				if (!status.walk_done) begin
					cmd.walk_step = 1'b1;
				end else if (out_free) begin
					// The finished date waits here until the output register is free.
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	`ASSERT_NEXT(a_accept_to_mod, in_valid && in_ready, state_q == ST_MOD, "accepted transfer did not start work")
	`ASSERT_SAME(a_no_overwrite, cmd.out_load, out_free, "result overwrote a pending transfer")
	`ASSERT_NEXT(a_load_shows, cmd.out_load, out_valid_q, "loaded result not offered")
	`ASSERT_ALWAYS(a_one_step, $onehot0({cmd.sum_step, cmd.walk_step, cmd.out_load, cmd.load}), "conflicting datapath commands")

endmodule

`default_nettype wire

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for add_days_to_date. It sends starting dates and day
// counts over the req channel and computes each end date in a local calendar
// model. Every rsp transfer is checked against the oldest pending date.
// Directed calendar corners come first, then random dates under several
// sender and receiver idle mixes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
	import dadd_pkg::*;

	localparam int unsigned DAYS_PER_MONTH [1:12] = '{
		31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic rsp_ready = 1'b0;

	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned mismatch_count = 0;

	dadd_out_t pending_dates [$];

	dadd_in_if  req_if ();
	dadd_out_if rsp_if ();

	assign rsp_if.ready = rsp_ready;

	add_days_to_date u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	always #10 clk = ~clk;

	// Month outside 1..12 counts as zero days.
	function automatic int unsigned month_length(input logic [YEAR_W-1:0] yr,
		input int unsigned mo);
		bit leap_year;
		leap_year = (yr % 400 == 0) || ((yr % 100 != 0) && (yr % 4 == 0));
		if (mo < 1 || mo > 12)
			return 0;
		if (mo == 2)
			return leap_year ? 29 : 28;
		return DAYS_PER_MONTH[mo];
	endfunction

	function automatic dadd_out_t end_date(input dadd_in_t d);
		logic [YEAR_W-1:0] yr;
		int unsigned left;
		int unsigned mo;
		dadd_out_t res;
		yr = d.start_year;
		left = d.days_to_add + d.start_day;
		for (mo = 1; mo < d.start_month; mo++)
			left += month_length(yr, mo);
		// Walk forward from January; the year wraps at its 14-bit width.
		mo = 1;
		while (left > month_length(yr, mo)) begin
			left -= month_length(yr, mo);
			mo++;
			if (mo > 12) begin
				mo = 1;
				yr = yr + 1'b1;
			end
		end
		res.end_year = yr;
		res.end_month = mo[MONTH_W-1:0];
		res.end_day = left[DAY_W-1:0];
		return res;
	endfunction

	// Sends one date, idling first as the current mix asks, and records the
	// expected end date once the transfer happens.
	task automatic send_date(input int unsigned yr, input int unsigned mo,
		input int unsigned dy, input int unsigned cnt);
		dadd_in_t item;
		item.start_year = yr[YEAR_W-1:0];
		item.start_month = mo[MONTH_W-1:0];
		item.start_day = dy[DAY_W-1:0];
		item.days_to_add = cnt[COUNT_W-1:0];
		while ($urandom_range(99) < send_idle_pct) begin
			req_if.valid <= 1'b0;
			req_if.data <= dadd_in_t'({$urandom, $urandom});
			@(posedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.data <= item;
		do @(posedge clk); while (!req_if.ready);
		pending_dates.push_back(end_date(item));
	endtask

	task automatic random_dates(input int n);
		int unsigned yr;
		int unsigned mo;
		int unsigned dy;
		int unsigned cnt;
		int unsigned pick;
		repeat (n) begin
			yr = $urandom_range(16383);
			mo = ($urandom_range(99) < 85) ? $urandom_range(1, 12) : $urandom_range(15);
			if ($urandom_range(99) < 80 && mo >= 1 && mo <= 12)
				dy = $urandom_range(1, month_length(yr[YEAR_W-1:0], mo));
			else
				dy = $urandom_range(31);
			// Long counts walk thousands of months, so most counts stay short.
			pick = $urandom_range(99);
			if (pick < 70)
				cnt = $urandom_range(400);
			else if (pick < 90)
				cnt = $urandom_range(65535);
			else
				cnt = $urandom_range(65000, 65535);
			send_date(yr, mo, dy, cnt);
		end
	endtask

	task automatic test_calendar_edges();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		send_date(0, 1, 1, 0);
		send_date(0, 0, 0, 0);
		send_date(0, 1, 0, 0);
		send_date(2000, 2, 28, 1);
		send_date(1900, 2, 28, 1);
		send_date(2024, 2, 29, 1);
		send_date(2023, 2, 28, 1);
		send_date(1999, 12, 31, 1);
		send_date(2023, 2, 31, 0);
		send_date(2023, 4, 31, 0);
		send_date(2023, 13, 1, 0);
		send_date(2023, 14, 5, 10);
		send_date(2023, 15, 31, 0);
		send_date(2023, 0, 15, 20);
		send_date(9999, 12, 31, 1);
		send_date(9999, 1, 1, 65535);
		send_date(16383, 12, 31, 1);
		send_date(16383, 15, 31, 65535);
		send_date(16383, 1, 1, 0);
		send_date(10752, 2, 29, 0);
		send_date(0, 12, 31, 65535);
		send_date(8191, 6, 16, 32768);
	endtask

	task automatic test_streaming();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		random_dates(62);
	endtask

	task automatic test_sender_gaps();
		send_idle_pct = 87;
		recv_stall_pct = 0;
		random_dates(62);
	endtask

	task automatic test_receiver_stalls();
		send_idle_pct = 0;
		recv_stall_pct = 87;
		random_dates(62);
	endtask

	task automatic test_mixed_idle();
		send_idle_pct = 22;
		recv_stall_pct = 22;
		random_dates(62);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ready <= 1'b0;
		end else begin
			if (rsp_if.valid && rsp_ready) begin : check_transfer
				dadd_out_t want;
				if (pending_dates.size() == 0) begin
					$display("%0t: unexpected result %0d-%0d-%0d", $time,
						rsp_if.data.end_year, rsp_if.data.end_month, rsp_if.data.end_day);
					mismatch_count++;
				end else begin
					want = pending_dates.pop_front();
					if (rsp_if.data.end_year !== want.end_year) begin
						$display("%0t: end_year expected %0d, actual %0d", $time,
							want.end_year, rsp_if.data.end_year);
						mismatch_count++;
					end
					if (rsp_if.data.end_month !== want.end_month) begin
						$display("%0t: end_month expected %0d, actual %0d", $time,
							want.end_month, rsp_if.data.end_month);
						mismatch_count++;
					end
					if (rsp_if.data.end_day !== want.end_day) begin
						$display("%0t: end_day expected %0d, actual %0d", $time,
							want.end_day, rsp_if.data.end_day);
						mismatch_count++;
					end
				end
			end
			rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	initial begin
		req_if.valid <= 1'b0;
		req_if.data <= '0;
		arst_n <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_calendar_edges();
		test_streaming();
		test_sender_gaps();
		test_receiver_stalls();
		test_mixed_idle();
		req_if.valid <= 1'b0;

		while (pending_dates.size() != 0)
			@(posedge clk);
		// Leave room for any stray transfer after the last expected one.
		repeat (50) @(posedge clk);

		if (mismatch_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	// About five times the slowest legal run of the whole sequence.
	initial begin
		#60000000;
		$display("%0t: timeout, %0d results still pending", $time, pending_dates.size());
		$display("tb: failure");
		$finish;
	end

endmodule
